/* rtl/hyp_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hyp_pkg
// Shared constants for the hypotenuse square-root pipeline.
// ----------------------------------------------------------------------------
package hyp_pkg;

	// Default leg width; the root is one bit wider.
	localparam int DEF_LEG_BITS = 16;

endpackage

/* rtl/hyp_leg_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hyp_leg_if
// Valid/ready channel carrying one pair of leg lengths per transaction.
// ----------------------------------------------------------------------------
interface hyp_leg_if #(
	parameter int LEG_BITS = hyp_pkg::DEF_LEG_BITS
) ();
	logic                valid;
	logic                ready;
	logic [LEG_BITS-1:0] leg_a;
	logic [LEG_BITS-1:0] leg_b;

	modport source (output valid, output leg_a, output leg_b, input ready);
	modport sink   (input valid, input leg_a, input leg_b, output ready);
endinterface

/* rtl/hyp_len_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hyp_len_if
// Valid/ready channel carrying one hypotenuse length per transaction.
// ----------------------------------------------------------------------------
interface hyp_len_if #(
	parameter int LEG_BITS = hyp_pkg::DEF_LEG_BITS
) ();
	logic              valid;
	logic              ready;
	logic [LEG_BITS:0] hypotenuse_len;

	modport source (output valid, output hypotenuse_len, input ready);
	modport sink   (input valid, input hypotenuse_len, output ready);
endinterface

/* rtl/hyp_sumsq.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hyp_sumsq
// Two-stage front end: square both legs, then add the squares.
// ----------------------------------------------------------------------------
module hyp_sumsq #(
	parameter int LEG_BITS = hyp_pkg::DEF_LEG_BITS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [LEG_BITS-1:0]   leg_a,
	input  logic [LEG_BITS-1:0]   leg_b,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [2*LEG_BITS:0]   sum
);
	localparam int SQ_W = 2 * LEG_BITS;

	logic              valid_s1;
	logic              valid_s2;
	logic [SQ_W-1:0]   sq_a_s1;
	logic [SQ_W-1:0]   sq_b_s1;
	logic [SQ_W:0]     sum_s2;
	logic              ready_s1;
	logic              ready_s2;

	assign ready_s2 = !valid_s2 || out_ready;
	assign ready_s1 = !valid_s1 || ready_s2;
	assign in_ready = ready_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (ready_s1) valid_s1 <= in_valid;
			if (ready_s2) valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && ready_s1) begin
			sq_a_s1 <= {{LEG_BITS{1'b0}}, leg_a} * {{LEG_BITS{1'b0}}, leg_a};
			sq_b_s1 <= {{LEG_BITS{1'b0}}, leg_b} * {{LEG_BITS{1'b0}}, leg_b};
		end
		if (valid_s1 && ready_s2) begin
			sum_s2 <= {1'b0, sq_a_s1} + {1'b0, sq_b_s1};
		end
	end

	assign out_valid = valid_s2;
	assign sum       = sum_s2;
endmodule

/* rtl/hyp_root_step.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hyp_root_step
// One registered step of the radix-2 digit-by-digit square root.
// ----------------------------------------------------------------------------
module hyp_root_step #(
	parameter int LEG_BITS = hyp_pkg::DEF_LEG_BITS,
	parameter int STEP     = 0
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [2*LEG_BITS:0]   rem_in,
	input  logic [2*LEG_BITS+1:0] res_in,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [2*LEG_BITS:0]   rem_out,
	output logic [2*LEG_BITS+1:0] res_out
);
	localparam int RW = 2 * LEG_BITS + 1;
	localparam int W  = 2 * LEG_BITS + 2;
	// weight of the root bit decided here
	localparam logic [W-1:0] BIT = {{(W-1){1'b0}}, 1'b1} << (2 * (LEG_BITS - STEP));

	logic          valid_s1;
	logic [RW-1:0] rem_s1;
	logic [W-1:0]  res_s1;
	logic [W-1:0]  trial;
	logic [W-1:0]  diff;
	logic          keep;

	assign trial = res_in + BIT;
	assign keep  = {1'b0, rem_in} >= trial;
	assign diff  = {1'b0, rem_in} - trial;

	assign in_ready = !valid_s1 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			if (keep) begin
				rem_s1 <= diff[RW-1:0];
				res_s1 <= (res_in >> 1) + BIT;
			end else begin
				rem_s1 <= rem_in;
				res_s1 <= res_in >> 1;
			end
		end
	end

	assign out_valid = valid_s1;
	assign rem_out   = rem_s1;
	assign res_out   = res_s1;
endmodule

/* rtl/hypotenuse_square_root_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hypotenuse_square_root_top
// Floor of sqrt(a*a + b*b) on fixed-point legs, fully pipelined.
// ----------------------------------------------------------------------------
// One transaction per clock in and out while the output is not stalled. Each
// leg pair goes through a squaring stage, an add stage and LEG_BITS+1 root
// stages (one root bit per stage); the last root stage is the output
// register, where its result waits until the length channel takes it. The
// fixed-point point is implicit: legs with F fraction bits give a root with F
// fraction bits. Every stage has its own valid bit and accepts while it is
// empty or its successor moves, so a stalled output holds its result while
// bubbles further up keep filling; the leg channel is only held off once
// every stage is occupied. Leg bits are taken as unsigned LEG_BITS-bit values
// and the root never overflows LEG_BITS+1 bits.
// ----------------------------------------------------------------------------
module hypotenuse_square_root_top #(
	parameter int LEG_BITS = hyp_pkg::DEF_LEG_BITS
) (
	input  logic      clk,
	input  logic      arst_n,
	hyp_leg_if.sink   leg_in,
	hyp_len_if.source len_out
);
	localparam int RW    = 2 * LEG_BITS + 1;  // radicand / remainder width
	localparam int W     = 2 * LEG_BITS + 2;  // partial root width
	localparam int NSTEP = LEG_BITS + 1;      // root bits, one per stage

	// square/add front end output
	logic          sum_valid;
	logic [RW-1:0] sum;

	// root stage chain; index k is the input of step k
	logic          v_c   [0:NSTEP];
	logic          rdy_c [0:NSTEP];
	logic [RW-1:0] rem_c [0:NSTEP];
	logic [W-1:0]  res_c [0:NSTEP];

	hyp_sumsq #(
		.LEG_BITS (LEG_BITS)
	) u_sumsq (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (leg_in.valid),
		.in_ready  (leg_in.ready),
		.leg_a     (leg_in.leg_a),
		.leg_b     (leg_in.leg_b),
		.out_valid (sum_valid),
		.out_ready (rdy_c[0]),
		.sum       (sum)
	);

	// radicand enters with an empty partial root
	assign v_c[0]   = sum_valid;
	assign rem_c[0] = sum;
	assign res_c[0] = '0;

	for (genvar k = 0; k < NSTEP; k++) begin : g_step
		hyp_root_step #(
			.LEG_BITS (LEG_BITS),
			.STEP     (k)
		) u_step (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (v_c[k]),
			.in_ready  (rdy_c[k]),
			.rem_in    (rem_c[k]),
			.res_in    (res_c[k]),
			.out_valid (v_c[k+1]),
			.out_ready (rdy_c[k+1]),
			.rem_out   (rem_c[k+1]),
			.res_out   (res_c[k+1])
		);
	end

	// last stage is the output register; the root sits in its low bits
	assign rdy_c[NSTEP]          = len_out.ready;
	assign len_out.valid         = v_c[NSTEP];
	assign len_out.hypotenuse_len = res_c[NSTEP][LEG_BITS:0];

	// ------------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------------

	// a held first root stage must not be overwritten by the add stage
	a_first_hold: assert property (@(posedge clk) disable iff (!arst_n)
		v_c[1] && !rdy_c[1] |=> v_c[1] && $stable(rem_c[1]) && $stable(res_c[1]))
		else $error("first root stage lost or changed a held transaction");

	// the radicand waiting for the root chain stays put
	a_sum_hold: assert property (@(posedge clk) disable iff (!arst_n)
		sum_valid && !rdy_c[0] |=> sum_valid && $stable(sum))
		else $error("sum stage lost or changed a held transaction");

	// a stalled, full root chain must push back on the front end
	a_chain_full: assert property (@(posedge clk) disable iff (!arst_n)
		v_c[1] && !rdy_c[1] |-> !rdy_c[0] || !sum_valid)
		else $error("root chain accepted while its first stage was blocked");

	// the root register never holds more than LEG_BITS+1 significant bits
	a_root_range: assert property (@(posedge clk) disable iff (!arst_n)
		v_c[NSTEP] |-> (res_c[NSTEP] >> (LEG_BITS + 1)) == '0)
		else $error("partial root overflowed the result width");

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for hypotenuse_square_root_top.
// ----------------------------------------------------------------------------
// Leg pairs are queued up front, then driven in random bursts by a clocked
// driver. Every accepted pair is run through a local digit-by-digit floor
// root, and the expected length waits in a queue. A clocked monitor stalls
// the output on its own pattern, with two long hold-offs that back the
// pipeline up into the leg channel. It checks each returned length against
// the oldest expected one.
// ----------------------------------------------------------------------------
module tb;

	localparam int LEG_W      = hyp_pkg::DEF_LEG_BITS;
	localparam int LEN_W      = LEG_W + 1;
	localparam int SUM_W      = 2 * LEG_W + 1;
	localparam int LATENCY    = LEG_W + 3;   // squaring, add, one stage per root bit
	localparam int RAND_ITEMS = 650;
	localparam int HOLD_LEN   = 90;          // longer than the pipeline is deep
	localparam int CYCLE_CAP  = 250000;

	typedef struct packed {
		logic [LEG_W-1:0] a;
		logic [LEG_W-1:0] b;
	} leg_pair_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	hyp_leg_if #(.LEG_BITS(LEG_W)) leg_ch ();
	hyp_len_if #(.LEG_BITS(LEG_W)) len_ch ();

	hypotenuse_square_root_top #(.LEG_BITS(LEG_W)) DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.leg_in  (leg_ch),
		.len_out (len_ch)
	);

	// Pairs waiting to be offered, and lengths owed by the pipeline.
	leg_pair_t        pending_legs[$];
	logic [LEN_W-1:0] owed_lens[$];

	int legs_taken;    // accepted leg transactions
	int fail_count;
	int holdoff_left;  // cycles left in the current long output stall
	int holdoffs_done;

	// Sender burst state, touched only by the driver.
	int burst_left;
	int gap_left;

	// Receiver stall pattern, touched only by the monitor.
	int stall_mode;
	int stall_span;

	always #1 clk = ~clk;

	// Floor of sqrt(a*a + b*b), one root bit per step from the top.
	// Two spare bits above the sum keep the trial value from wrapping.
	function automatic logic [LEN_W-1:0] hyp_root(logic [LEG_W-1:0] a, logic [LEG_W-1:0] b);
		logic [SUM_W+1:0] rem;
		logic [SUM_W+1:0] root;
		logic [SUM_W+1:0] place;
		logic [SUM_W+1:0] trial;
		rem   = (SUM_W+2)'(a) * (SUM_W+2)'(a) + (SUM_W+2)'(b) * (SUM_W+2)'(b);
		root  = '0;
		place = (SUM_W+2)'(1) << (2 * LEG_W);
		for (int i = 0; i <= LEG_W; i++) begin
			trial = root + place;
			if (rem >= trial) begin
				rem  = rem - trial;
				root = (root >> 1) + place;
			end else begin
				root = root >> 1;
			end
			place = place >> 2;
		end
		return root[LEN_W-1:0];
	endfunction

	function automatic leg_pair_t mk_pair(int unsigned a, int unsigned b);
		leg_pair_t p;
		p.a = a[LEG_W-1:0];
		p.b = b[LEG_W-1:0];
		return p;
	endfunction

	// Random leg with a bias toward the corners of the range.
	function automatic int unsigned rand_leg();
		int unsigned top;
		top = (1 << LEG_W) - 1;
		case ($urandom_range(0, 5))
			0:       return $urandom_range(0, 255);             // under one unit
			1:       return top - $urandom_range(0, 255);       // close to full scale
			2:       return $urandom_range(0, 15) << 8;         // whole numbers
			default: return $urandom_range(0, top);
		endcase
	endfunction

	// ------------------------------------------------------------------------
	// Driver: pops pending pairs, holds them until taken, idles in gaps.
	// The predictor runs on the pair at the edge where it is accepted.
	// ------------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin : leg_driver
		leg_pair_t next_pair;
		if (!arst_n) begin
			leg_ch.valid <= 1'b0;
			leg_ch.leg_a <= '0;
			leg_ch.leg_b <= '0;
			legs_taken   <= 0;
			burst_left   = 0;
			gap_left     = 0;
		end else begin
			if (leg_ch.valid && leg_ch.ready) begin
				owed_lens.push_back(hyp_root(leg_ch.leg_a, leg_ch.leg_b));
				legs_taken <= legs_taken + 1;
			end
			// A pair still waiting stays on the bus untouched.
			if (!leg_ch.valid || leg_ch.ready) begin
				if (gap_left > 0) begin
					gap_left--;
					leg_ch.valid <= 1'b0;
				end else if (pending_legs.size() != 0) begin
					next_pair = pending_legs.pop_front();
					leg_ch.valid <= 1'b1;
					leg_ch.leg_a <= next_pair.a;
					leg_ch.leg_b <= next_pair.b;
					if (burst_left > 0) begin
						burst_left--;
					end else begin
						// End of burst: pick the next gap and burst length.
						// Zero gaps give long back-to-back stretches; the long
						// ones land on every stage of the pipeline.
						burst_left = $urandom_range(0, 40);
						case ($urandom_range(0, 3))
							0:       gap_left = 0;
							1:       gap_left = $urandom_range(LATENCY - 4, LATENCY + 6);
							default: gap_left = $urandom_range(1, 6);
						endcase
					end
				end else begin
					leg_ch.valid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// Long hold-offs of the output, counted here. Each starts once enough
	// legs have gone in, while the sender keeps offering, so the pipeline
	// fills and has to refuse legs.
	// ------------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			holdoff_left  <= 0;
			holdoffs_done <= 0;
		end else if (holdoff_left != 0) begin
			holdoff_left <= holdoff_left - 1;
		end else if (holdoffs_done < 2 && legs_taken >= 150 + 300 * holdoffs_done) begin
			holdoff_left  <= HOLD_LEN;
			holdoffs_done <= holdoffs_done + 1;
		end
	end

	// ------------------------------------------------------------------------
	// Monitor: checks every length taken, then sets ready for the next edge.
	// ------------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin : len_monitor
		logic [LEN_W-1:0] want;
		logic             take;
		if (!arst_n) begin
			len_ch.ready <= 1'b0;
			stall_mode   = 0;
			stall_span   = 0;
		end else begin
			if (len_ch.valid && len_ch.ready) begin
				if (owed_lens.size() == 0) begin
					$error("hypotenuse_len: no transaction expected, actual %0d",
						len_ch.hypotenuse_len);
					fail_count++;
				end else begin
					want = owed_lens.pop_front();
					if (len_ch.hypotenuse_len !== want) begin
						$error("hypotenuse_len: expected %0d, actual %0d",
							want, len_ch.hypotenuse_len);
						fail_count++;
					end
				end
			end
			// Stall pattern: modes of random span, one of them never stalls.
			if (stall_span == 0) begin
				stall_mode = $urandom_range(0, 3);
				stall_span = $urandom_range(4, 60);
			end else begin
				stall_span--;
			end
			case (stall_mode)
				0:       take = 1'b1;
				1:       take = ($urandom_range(0, 1) == 0);
				2:       take = ($urandom_range(0, 3) == 0);
				default: take = ($urandom_range(0, 7) != 0);
			endcase
			len_ch.ready <= take && (holdoff_left == 0);
		end
	end

	// Watchdog.
	always @(posedge clk) begin : watchdog
		int cycles;
		cycles++;
		if (cycles > CYCLE_CAP) begin
			$display("hypotenuse_square_root_top test failed");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// Stimulus, reset and end of run.
	// ------------------------------------------------------------------------
	initial begin
		int unsigned top;
		int unsigned k;
		int unsigned u;
		int unsigned v;
		int          n_legs;
		top = (1 << LEG_W) - 1;

		// Known levels before the first edge.
		leg_ch.valid = 1'b0;
		leg_ch.leg_a = '0;
		leg_ch.leg_b = '0;
		len_ch.ready = 1'b0;
		fail_count   = 0;

		// Directed: zero legs, full scale, lone legs, exact roots, odd bits.
		pending_legs.push_back(mk_pair(0, 0));
		pending_legs.push_back(mk_pair(top, top));       // largest root
		pending_legs.push_back(mk_pair(top, 0));
		pending_legs.push_back(mk_pair(0, top));
		pending_legs.push_back(mk_pair(1, 0));
		pending_legs.push_back(mk_pair(0, 1));
		pending_legs.push_back(mk_pair(1, 1));           // root 2 truncates
		pending_legs.push_back(mk_pair(3 << 8, 4 << 8)); // exact 5.0
		pending_legs.push_back(mk_pair(5, 12));          // exact in raw units
		pending_legs.push_back(mk_pair(8, 15));
		pending_legs.push_back(mk_pair(20 << 4, 21 << 4));
		pending_legs.push_back(mk_pair(1 << 8, 0));
		pending_legs.push_back(mk_pair(1 << (LEG_W - 1), 1 << (LEG_W - 1)));
		pending_legs.push_back(mk_pair(16'h5555, 16'hAAAA));
		pending_legs.push_back(mk_pair(16'hAAAA, 16'h5555));
		pending_legs.push_back(mk_pair(1, top));
		pending_legs.push_back(mk_pair(top, 1));
		pending_legs.push_back(mk_pair(top - 1, top - 1));
		pending_legs.push_back(mk_pair(16'h00FF, 16'hFF00));

		// Random: corner-biased legs, plus scaled triples whose root is exact.
		repeat (RAND_ITEMS) begin
			if ($urandom_range(0, 7) == 0) begin
				u = $urandom_range(2, 90);
				v = $urandom_range(1, u - 1);
				k = $urandom_range(1, 4);
				pending_legs.push_back(mk_pair(k * (u * u - v * v), k * 2 * u * v));
			end else begin
				pending_legs.push_back(mk_pair(rand_leg(), rand_leg()));
			end
		end
		n_legs = pending_legs.size();

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Everything taken, then every length back.
		while (legs_taken != n_legs) @(posedge clk);
		while (owed_lens.size() != 0) @(posedge clk);
		// Quiet period: anything that shows up now is an extra length.
		repeat (2 * LATENCY) @(posedge clk);

		if (fail_count == 0) begin
			$display("hypotenuse_square_root_top test passed");
		end else begin
			$display("hypotenuse_square_root_top test failed");
		end
		$finish;
	end

endmodule
